// ----- hw/rtl/asp_pkg.sv -----
// Package for the atlas shelf packer: sizes, payload structs, status codes,
// register indexes and the controller state type. It depends on nothing.
package asp_pkg;

    localparam int MaxAtlases = 8;
    localparam int IdxW = (MaxAtlases > 1) ? $clog2(MaxAtlases) : 1;
    localparam int OpenW = $clog2(MaxAtlases + 1);

    localparam int DimW = 13;
    localparam int RectW = 12;
    localparam int SumW = 14;
    localparam int CfgIdxW = 2;

    localparam logic [DimW-1:0] AtlasDimReset = 13'd512;

    typedef enum logic [1:0] {
        ST_PLACED   = 2'd0,
        ST_EMPTY    = 2'd1,
        ST_TOO_BIG  = 2'd2,
        ST_NO_ATLAS = 2'd3
    } t_status;

    typedef enum logic [CfgIdxW-1:0] {
        CFG_ATLAS_WIDTH  = 2'd0,
        CFG_ATLAS_HEIGHT = 2'd1
    } t_cfg_idx;

    typedef struct packed {
        logic [11:0] rect_width;
        logic [11:0] rect_height;
    } t_rect;

    typedef struct packed {
        logic [1:0]  status;
        logic [2:0]  atlas_index;
        logic [11:0] pos_x;
        logic [11:0] pos_y;
    } t_result;

    typedef enum logic [1:0] {
        S_IDLE,
        S_CHECK,
        S_SCAN,
        S_OPEN
    } t_state;

    typedef struct packed {
        logic load;
        logic scan_next;
        logic commit_fit;
        logic open_new;
        logic emit_empty;
        logic emit_large;
        logic emit_full;
    } t_dp_cmd;

    typedef struct packed {
        logic is_empty;
        logic too_large;
        logic fits;
        logic last_open;
        logic all_open;
    } t_dp_stat;

endpackage

// ----- hw/rtl/asp_ctrl.sv -----
// Controller state machine of the atlas shelf packer.
// Depends on asp_pkg for the state type and the command and status structs.
module asp_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              start,
    input  asp_pkg::t_dp_stat i_stat,
    output asp_pkg::t_dp_cmd  o_cmd,
    output logic              busy
);

    asp_pkg::t_state r_state;
    asp_pkg::t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= asp_pkg::S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        unique case (r_state)
            asp_pkg::S_IDLE: begin
                if (start) begin
                    o_cmd.load = 1'b1;
                    n_state    = asp_pkg::S_CHECK;
                end
            end
            asp_pkg::S_CHECK: begin
                if (i_stat.is_empty) begin
                    o_cmd.emit_empty = 1'b1;
                    n_state          = asp_pkg::S_IDLE;
                end else if (i_stat.too_large) begin
                    o_cmd.emit_large = 1'b1;
                    n_state          = asp_pkg::S_IDLE;
                end else begin
                    n_state = asp_pkg::S_SCAN;
                end
            end
            asp_pkg::S_SCAN: begin
                if (i_stat.fits) begin
                    o_cmd.commit_fit = 1'b1;
                    n_state          = asp_pkg::S_IDLE;
                end else if (i_stat.last_open) begin
                    n_state = asp_pkg::S_OPEN;
                end else begin
                    o_cmd.scan_next = 1'b1;
                end
            end
            asp_pkg::S_OPEN: begin
                if (i_stat.all_open) begin
                    o_cmd.emit_full = 1'b1;
                end else begin
                    o_cmd.open_new = 1'b1;
                end
                n_state = asp_pkg::S_IDLE;
            end
            default: begin
                n_state = asp_pkg::S_IDLE;
            end
        endcase
    end

    assign busy = (r_state != asp_pkg::S_IDLE);

endmodule

// ----- hw/rtl/asp_datapath.sv -----
// Datapath of the atlas shelf packer: configuration registers, per-atlas
// cursors, the fit test for one atlas per cycle and the result register.
// Depends on asp_pkg.
module asp_datapath (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  asp_pkg::t_rect              i_rect,
    input  logic                        i_cfg_valid,
    input  logic [asp_pkg::CfgIdxW-1:0] i_cfg_index,
    input  logic [15:0]                 i_cfg_data,
    input  asp_pkg::t_dp_cmd            i_cmd,
    output asp_pkg::t_dp_stat           o_stat,
    output asp_pkg::t_result            o_result,
    output logic                        o_result_valid
);

    localparam int DW = asp_pkg::DimW;
    localparam int SW = asp_pkg::SumW;
    localparam int IW = asp_pkg::IdxW;
    localparam int OW = asp_pkg::OpenW;
    localparam int NA = asp_pkg::MaxAtlases;

    logic [DW-1:0] r_aw;
    logic [DW-1:0] r_ah;
    logic [DW-1:0] r_cursor [NA];
    logic [DW-1:0] r_shelf  [NA];
    logic [DW-1:0] r_filled [NA];
    logic [OW-1:0] r_open;
    logic [IW-1:0] r_idx;
    logic [11:0]   r_w;
    logic [11:0]   r_h;
    asp_pkg::t_result r_res;
    logic             r_res_valid;

    logic [SW-1:0] x_cur;
    logic [SW-1:0] top_cur;
    logic [SW-1:0] bot_cur;
    logic [SW-1:0] w_ext;
    logic [SW-1:0] h_ext;
    logic [SW-1:0] reach_x;
    logic          new_shelf;
    logic [SW-1:0] place_x;
    logic [SW-1:0] place_y;
    logic [SW-1:0] end_x;
    logic [SW-1:0] end_y;
    logic [IW-1:0] open_idx;
    asp_pkg::t_result n_res;
    logic             n_res_valid;

    always_comb begin
        w_ext     = SW'(r_w);
        h_ext     = SW'(r_h);
        x_cur     = SW'(r_cursor[r_idx]);
        top_cur   = SW'(r_shelf[r_idx]);
        bot_cur   = SW'(r_filled[r_idx]);
        reach_x   = x_cur + w_ext + SW'(1);
        new_shelf = (reach_x >= SW'(r_aw));
        place_x   = new_shelf ? SW'(1) : x_cur;
        place_y   = new_shelf ? (bot_cur + SW'(1)) : top_cur;
        end_x     = place_x + w_ext + SW'(1);
        end_y     = place_y + h_ext + SW'(1);
        open_idx  = r_open[IW-1:0];

        o_stat.is_empty  = (r_w == '0) || (r_h == '0);
        o_stat.too_large = ((w_ext + SW'(2)) >= SW'(r_aw)) ||
                           ((h_ext + SW'(2)) >= SW'(r_ah));
        o_stat.fits      = (end_y < SW'(r_ah));
        o_stat.last_open = ((OW'(r_idx) + OW'(1)) == r_open);
        o_stat.all_open  = (r_open == OW'(NA));
    end

    always_comb begin
        n_res       = '0;
        n_res_valid = 1'b1;
        if (i_cmd.commit_fit) begin
            n_res.status      = asp_pkg::ST_PLACED;
            n_res.atlas_index = 3'(r_idx);
            n_res.pos_x       = place_x[11:0];
            n_res.pos_y       = place_y[11:0];
        end else if (i_cmd.open_new) begin
            n_res.status      = asp_pkg::ST_PLACED;
            n_res.atlas_index = 3'(open_idx);
            n_res.pos_x       = 12'd1;
            n_res.pos_y       = 12'd1;
        end else if (i_cmd.emit_empty) begin
            n_res.status = asp_pkg::ST_EMPTY;
        end else if (i_cmd.emit_large) begin
            n_res.status = asp_pkg::ST_TOO_BIG;
        end else if (i_cmd.emit_full) begin
            n_res.status = asp_pkg::ST_NO_ATLAS;
        end else begin
            n_res_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_aw        <= asp_pkg::AtlasDimReset;
            r_ah        <= asp_pkg::AtlasDimReset;
            r_open      <= OW'(1);
            r_idx       <= '0;
            r_res_valid <= 1'b0;
            for (int i = 0; i < NA; i++) begin
                r_cursor[i] <= DW'(1);
                r_shelf[i]  <= DW'(1);
                r_filled[i] <= DW'(1);
            end
        end else begin
            r_res_valid <= n_res_valid;
            if (i_cfg_valid) begin
                if (i_cfg_index == asp_pkg::CFG_ATLAS_WIDTH) begin
                    r_aw <= i_cfg_data[DW-1:0];
                end else if (i_cfg_index == asp_pkg::CFG_ATLAS_HEIGHT) begin
                    r_ah <= i_cfg_data[DW-1:0];
                end
            end
            if (i_cmd.load) begin
                r_idx <= '0;
            end else if (i_cmd.scan_next) begin
                r_idx <= r_idx + IW'(1);
            end
            if (i_cmd.commit_fit) begin
                r_cursor[r_idx] <= end_x[DW-1:0];
                r_shelf[r_idx]  <= place_y[DW-1:0];
                if (end_y > bot_cur) begin
                    r_filled[r_idx] <= end_y[DW-1:0];
                end
            end
            if (i_cmd.open_new) begin
                r_cursor[open_idx] <= DW'(w_ext + SW'(2));
                r_shelf[open_idx]  <= DW'(1);
                r_filled[open_idx] <= DW'(h_ext + SW'(2));
                r_open             <= r_open + OW'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_w <= i_rect.rect_width;
            r_h <= i_rect.rect_height;
        end
        r_res <= n_res;
    end

    assign o_result       = r_res;
    assign o_result_valid = r_res_valid;

endmodule

// ----- hw/rtl/atlas_shelf_packer.sv -----
// Top level of the atlas shelf packer: joins the controller and the datapath.
// Depends on asp_pkg, asp_ctrl and asp_datapath.
//
// Usage: drive i_rect and raise start while busy is low; the transaction is
// taken at that edge and busy rises on the next cycle. Exactly one result
// follows per transaction, shown on o_result for one cycle with o_result_valid
// high. The receiver cannot stall, so the result must be captured then.
// After the accepting edge the controller checks the rectangle and reports an
// empty or oversized one from that check; otherwise it scans the open atlases
// from atlas 0 until one fits, and after the last open one it opens a new atlas
// for it or reports that none is left. The scan visits one atlas per cycle
// through a single cursor lookup and fit test. busy falls in the cycle the result
// register loads, so the next transaction may be taken while the result shows.
// Configuration: i_cfg_index 0 writes the atlas width, 1 the atlas height, other
// indexes are ignored; o_cfg_ready is always high and writes belong to idle time.
// Reset (synchronous, active low) sets both dimensions to 512, all atlas cursors
// to 1 and one atlas open.
module atlas_shelf_packer (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        start,
    output logic                        busy,
    input  asp_pkg::t_rect              i_rect,
    output asp_pkg::t_result            o_result,
    output logic                        o_result_valid,
    input  logic                        i_cfg_valid,
    output logic                        o_cfg_ready,
    input  logic [asp_pkg::CfgIdxW-1:0] i_cfg_index,
    input  logic [15:0]                 i_cfg_data
);

    asp_pkg::t_dp_cmd  cmd;
    asp_pkg::t_dp_stat stat;

    assign o_cfg_ready = 1'b1;

    asp_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .start   (start),
        .i_stat  (stat),
        .o_cmd   (cmd),
        .busy    (busy)
    );

    asp_datapath u_datapath (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_rect         (i_rect),
        .i_cfg_valid    (i_cfg_valid),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data),
        .i_cmd          (cmd),
        .o_stat         (stat),
        .o_result       (o_result),
        .o_result_valid (o_result_valid)
    );

    a_result_from_job: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_result_valid |-> $past(busy))
        else $error("result strobe without a running transaction");

    a_status_fields_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_result_valid && (o_result.status != asp_pkg::ST_PLACED)) |->
        ((o_result.atlas_index == '0) && (o_result.pos_x == '0) &&
         (o_result.pos_y == '0)))
        else $error("non-placed result carries a position");

    a_start_goes_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> busy)
        else $error("accepted transaction did not start the controller");

    a_single_command: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot0(cmd))
        else $error("controller issued more than one command");

endmodule

// ----- dv/tb_atlas_shelf_packer.sv -----
// Self-checking testbench for atlas_shelf_packer: a directed table of rectangles,
// then phases of random rectangles under several atlas sizes, checked against a
// shelf packing predictor or a typed row's table result; needs asp_pkg, the RTL.
module tb_atlas_shelf_packer;

    localparam int CfgIdxW = asp_pkg::CfgIdxW;
    localparam int DimW = asp_pkg::DimW;
    localparam int MaxAtlases = asp_pkg::MaxAtlases;
    localparam int RectW = asp_pkg::RectW;
    localparam int WatchdogLimit = 4000;
    localparam int DrainCycles = 16;
    localparam int NumPhases = 10;
    localparam int CfgIdxCount = 1 << CfgIdxW;
    localparam int RectMax = (1 << RectW) - 1;

    typedef struct {
        logic [11:0]      w;
        logic [11:0]      h;
        bit               typed;
        asp_pkg::t_result res;
    } t_dir_row;

    logic               i_clk;
    logic               i_rst_n;
    logic               start;
    logic               busy;
    asp_pkg::t_rect     i_rect;
    asp_pkg::t_result   o_result;
    logic               o_result_valid;
    logic               i_cfg_valid;
    logic               o_cfg_ready;
    logic [CfgIdxW-1:0] i_cfg_index;
    logic [15:0]        i_cfg_data;

    logic [DimW-1:0] shelf_width;
    logic [DimW-1:0] shelf_height;
    logic [DimW-1:0] shelf_cursor_x [MaxAtlases];
    logic [DimW-1:0] shelf_top [MaxAtlases];
    logic [DimW-1:0] shelf_bottom [MaxAtlases];
    int unsigned     atlases_in_use;

    asp_pkg::t_result placements_due[$];
    int               n_errors;
    int               n_rects_taken;
    int               n_writes_taken;
    int               idle_cycles;
    bit               drv_typed;
    asp_pkg::t_result drv_typed_res;

    atlas_shelf_packer u_top (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .start         (start),
        .busy          (busy),
        .i_rect        (i_rect),
        .o_result      (o_result),
        .o_result_valid(o_result_valid),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data)
    );

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    task automatic clear_shelves();
        shelf_width = asp_pkg::AtlasDimReset;
        shelf_height = asp_pkg::AtlasDimReset;
        for (int i = 0; i < MaxAtlases; i++) begin
            shelf_cursor_x[i] = DimW'(1);
            shelf_top[i] = DimW'(1);
            shelf_bottom[i] = DimW'(1);
        end
        atlases_in_use = 1;
    endtask

    function automatic asp_pkg::t_result place_rect(asp_pkg::t_rect r);
        int unsigned w, h, x, y0, bot, i, aw, ah;
        asp_pkg::t_result res;
        res = '0;
        w = 32'(r.rect_width);
        h = 32'(r.rect_height);
        aw = 32'(shelf_width);
        ah = 32'(shelf_height);
        if (w == 0 || h == 0) begin
            res.status = asp_pkg::ST_EMPTY;
            return res;
        end
        if (w + 2 >= aw || h + 2 >= ah) begin
            res.status = asp_pkg::ST_TOO_BIG;
            return res;
        end
        for (i = 0; i < atlases_in_use && i < MaxAtlases; i++) begin
            x = 32'(shelf_cursor_x[i]);
            y0 = 32'(shelf_top[i]);
            bot = 32'(shelf_bottom[i]);
            if (x + w + 1 >= aw) begin
                y0 = bot + 1;
                x = 1;
            end
            if (y0 + h + 1 < ah) begin
                shelf_top[i] = DimW'(y0);
                shelf_cursor_x[i] = DimW'(x + w + 1);
                if (y0 + h + 1 > bot) begin
                    shelf_bottom[i] = DimW'(y0 + h + 1);
                end
                res.status = asp_pkg::ST_PLACED;
                res.atlas_index = 3'(i);
                res.pos_x = 12'(x);
                res.pos_y = 12'(y0);
                return res;
            end
        end
        if (atlases_in_use >= MaxAtlases) begin
            res.status = asp_pkg::ST_NO_ATLAS;
            return res;
        end
        i = atlases_in_use;
        atlases_in_use++;
        shelf_top[i] = DimW'(1);
        shelf_cursor_x[i] = DimW'(w + 2);
        shelf_bottom[i] = DimW'(h + 2);
        res.status = asp_pkg::ST_PLACED;
        res.atlas_index = 3'(i);
        res.pos_x = 12'd1;
        res.pos_y = 12'd1;
        return res;
    endfunction

    task automatic compare_field(string name, logic [11:0] want, logic [11:0] got);
        if (want !== got) begin
            $error("%s: expected %0d, got %0d", name, want, got);
            n_errors++;
        end
    endtask

    always @(posedge i_clk) begin : monitor
        asp_pkg::t_result want;
        bit               moved;
        moved = 1'b0;
        if (i_rst_n) begin
            if (o_result_valid) begin
                moved = 1'b1;
                if (placements_due.size() == 0) begin
                    $error("result transaction with no placement pending");
                    n_errors++;
                end else begin
                    want = placements_due.pop_front();
                    compare_field("status", 12'(want.status), 12'(o_result.status));
                    compare_field("atlas_index", 12'(want.atlas_index),
                                  12'(o_result.atlas_index));
                    compare_field("pos_x", want.pos_x, o_result.pos_x);
                    compare_field("pos_y", want.pos_y, o_result.pos_y);
                end
            end
            if (start && !busy) begin
                moved = 1'b1;
                want = place_rect(i_rect);
                if (drv_typed) begin
                    want = drv_typed_res;
                end
                placements_due.push_back(want);
                n_rects_taken <= n_rects_taken + 1;
            end
            if (i_cfg_valid && o_cfg_ready) begin
                moved = 1'b1;
                case (i_cfg_index)
                    asp_pkg::CFG_ATLAS_WIDTH: shelf_width = i_cfg_data[DimW-1:0];
                    asp_pkg::CFG_ATLAS_HEIGHT: shelf_height = i_cfg_data[DimW-1:0];
                    default: ;
                endcase
                n_writes_taken <= n_writes_taken + 1;
            end
            idle_cycles = moved ? 0 : idle_cycles + 1;
            if (idle_cycles >= WatchdogLimit) begin
                $display("tb_atlas_shelf_packer: errors");
                $finish;
            end
        end
    end

    task automatic send_rect(asp_pkg::t_rect r, bit typed, asp_pkg::t_result res);
        int taken;
        taken = n_rects_taken;
        i_rect = r;
        drv_typed = typed;
        drv_typed_res = res;
        start = 1'b1;
        do @(negedge i_clk); while (n_rects_taken == taken);
    endtask

    task automatic idle_between(bit burst);
        int roll, gap;
        roll = $urandom_range(99);
        gap = 0;
        if (!burst && roll >= 90) begin
            gap = $urandom_range(6, 40);
        end else if (!burst && roll >= 55) begin
            gap = $urandom_range(1, 3);
        end
        if (gap > 0) begin
            start = 1'b0;
            repeat (gap) @(negedge i_clk);
        end
    endtask

    task automatic write_reg(logic [CfgIdxW-1:0] idx, logic [15:0] data);
        int taken;
        taken = n_writes_taken;
        i_cfg_index = idx;
        i_cfg_data = data;
        i_cfg_valid = 1'b1;
        do @(negedge i_clk); while (n_writes_taken == taken);
        i_cfg_valid = 1'b0;
    endtask

    task automatic wait_drained();
        start = 1'b0;
        drv_typed = 1'b0;
        while (placements_due.size() != 0) @(negedge i_clk);
        repeat (DrainCycles) @(negedge i_clk);
    endtask

    function automatic logic [11:0] clamp_dim(int v);
        if (v < 0) begin
            return '0;
        end
        return (v > RectMax) ? RectMax[11:0] : v[11:0];
    endfunction

    function automatic asp_pkg::t_rect random_rect(int unsigned aw, int unsigned ah);
        asp_pkg::t_rect r;
        int roll, cw, ch;
        roll = $urandom_range(99);
        cw = (aw / 10 < 1) ? 1 : int'(aw / 10);
        ch = (ah / 10 < 1) ? 1 : int'(ah / 10);
        r.rect_width = clamp_dim(int'($urandom_range(1, cw)));
        r.rect_height = clamp_dim(int'($urandom_range(1, ch)));
        if (roll >= 94) begin
            r.rect_width = 12'($urandom);
            r.rect_height = 12'($urandom);
        end else if (roll >= 90) begin
            if ($urandom_range(1)) begin
                r.rect_width = '0;
            end else begin
                r.rect_height = '0;
            end
        end else if (roll >= 80) begin
            if ($urandom_range(1)) begin
                r.rect_width = clamp_dim(int'(aw) - int'($urandom_range(2, 3)));
            end else begin
                r.rect_height = clamp_dim(int'(ah) - int'($urandom_range(2, 3)));
            end
        end
        return r;
    endfunction

    function automatic void plan_phase(int p, output int unsigned aw,
                                       output int unsigned ah, output int count);
        case (p)
            0: begin aw = 0;    ah = 4096; count = 20;  end
            1: begin aw = 2;    ah = 4096; count = 20;  end
            2: begin aw = 4096; ah = 2;    count = 20;  end
            3: begin aw = 32;   ah = 32;   count = 40;  end
            4: begin aw = 700;  ah = 540;  count = 150; end
            5: begin aw = 1024; ah = 1024; count = 150; end
            6: begin aw = 1600; ah = 2048; count = 150; end
            7: begin aw = 2500; ah = 2500; count = 150; end
            8: begin aw = 4096; ah = 4096; count = 150; end
            default: begin aw = 8191; ah = 8191; count = 280; end
        endcase
    endfunction

    function automatic t_dir_row dir_row(int w, int h, bit typed, asp_pkg::t_status st,
                                         int idx, int x, int y);
        t_dir_row row;
        row.w = w[11:0];
        row.h = h[11:0];
        row.typed = typed;
        row.res.status = st;
        row.res.atlas_index = idx[2:0];
        row.res.pos_x = x[11:0];
        row.res.pos_y = y[11:0];
        return row;
    endfunction

    initial begin : stimulus
        t_dir_row       dir_rows[$];
        asp_pkg::t_rect r;
        int unsigned    aw, ah;
        int             count;
        bit             burst;

        i_rst_n = 1'b0;
        start = 1'b0;
        i_rect = '0;
        i_cfg_valid = 1'b0;
        i_cfg_index = '0;
        i_cfg_data = '0;
        drv_typed = 1'b0;
        drv_typed_res = '0;
        n_errors = 0;
        n_rects_taken = 0;
        n_writes_taken = 0;
        idle_cycles = 0;
        clear_shelves();

        dir_rows.push_back(dir_row(0, 0, 1, asp_pkg::ST_EMPTY, 0, 0, 0));
        dir_rows.push_back(dir_row(0, RectMax, 1, asp_pkg::ST_EMPTY, 0, 0, 0));
        dir_rows.push_back(dir_row(RectMax, 0, 1, asp_pkg::ST_EMPTY, 0, 0, 0));
        dir_rows.push_back(dir_row(RectMax, RectMax, 1, asp_pkg::ST_TOO_BIG, 0, 0, 0));
        dir_rows.push_back(dir_row(510, 1, 1, asp_pkg::ST_TOO_BIG, 0, 0, 0));
        dir_rows.push_back(dir_row(1, 510, 1, asp_pkg::ST_TOO_BIG, 0, 0, 0));
        dir_rows.push_back(dir_row(509, 509, 1, asp_pkg::ST_PLACED, 0, 1, 1));
        dir_rows.push_back(dir_row(1, 1, 0, asp_pkg::ST_PLACED, 0, 0, 0));
        for (int i = 2; i < MaxAtlases; i++) begin
            dir_rows.push_back(dir_row(509, 509, 0, asp_pkg::ST_PLACED, 0, 0, 0));
        end
        dir_rows.push_back(dir_row(509, 509, 1, asp_pkg::ST_NO_ATLAS, 0, 0, 0));
        dir_rows.push_back(dir_row(1, 1, 0, asp_pkg::ST_PLACED, 0, 0, 0));
        dir_rows.push_back(dir_row(508, 1, 0, asp_pkg::ST_PLACED, 0, 0, 0));
        dir_rows.push_back(dir_row(1, 508, 0, asp_pkg::ST_PLACED, 0, 0, 0));
        dir_rows.push_back(dir_row(12'hAAA, 12'h555, 1, asp_pkg::ST_TOO_BIG, 0, 0, 0));
        dir_rows.push_back(dir_row(12'h555, 12'hAAA, 1, asp_pkg::ST_TOO_BIG, 0, 0, 0));
        dir_rows.push_back(dir_row(0, 1, 1, asp_pkg::ST_EMPTY, 0, 0, 0));

        repeat (12) @(negedge i_clk);
        i_rst_n = 1'b1;
        @(negedge i_clk);

        foreach (dir_rows[k]) begin
            r.rect_width = dir_rows[k].w;
            r.rect_height = dir_rows[k].h;
            send_rect(r, dir_rows[k].typed, dir_rows[k].res);
            idle_between(1'b0);
        end
        wait_drained();

        for (int p = 0; p < NumPhases; p++) begin
            plan_phase(p, aw, ah, count);
            write_reg(asp_pkg::CFG_ATLAS_WIDTH, {3'($urandom), 13'(aw)});
            write_reg(asp_pkg::CFG_ATLAS_HEIGHT, {3'($urandom), 13'(ah)});
            for (int idx = asp_pkg::CFG_ATLAS_HEIGHT + 1; idx < CfgIdxCount; idx++) begin
                write_reg(idx[CfgIdxW-1:0], 16'($urandom));
            end
            burst = ($urandom_range(3) == 0);
            repeat (count) begin
                send_rect(random_rect(aw, ah), 1'b0, '0);
                idle_between(burst);
            end
            wait_drained();
        end

        if (n_errors == 0) begin
            $display("tb_atlas_shelf_packer: clean");
        end else begin
            $display("tb_atlas_shelf_packer: errors");
        end
        $finish;
    end

endmodule

// ----- sim.f -----
hw/rtl/asp_pkg.sv
hw/rtl/asp_ctrl.sv
hw/rtl/asp_datapath.sv
hw/rtl/atlas_shelf_packer.sv
dv/tb_atlas_shelf_packer.sv
